### rtl/rrds_pkg.sv
package rrds_pkg;

   localparam int NUM_TASKS = 8;
   localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int CNT_W     = $clog2(NUM_TASKS + 1);
   localparam int PAD_W     = (NUM_TASKS > 8) ? NUM_TASKS : 8;
   localparam int DELAY_W   = 32;

   localparam logic [DELAY_W-1:0] BLOCKED_FOREVER = 32'hFFFF_FFFF;

   localparam logic [1:0] MODE_SCHED = 2'd0;
   localparam logic [1:0] MODE_SET   = 2'd1;
   localparam logic [1:0] MODE_SELF  = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [2:0]         task_req;
      logic [DELAY_W-1:0] delay;
   } req_type;

   typedef struct packed {
      logic [2:0] running_task;
      logic [7:0] ready_mask;
      logic       ignored;
   } rsp_type;

   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   addr;
      logic [DELAY_W-1:0] data;
   } wr_cmd_type;

endpackage

### rtl/round_robin_delay_scheduler.sv
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_stall  req_data: mode, task_req, delay
//  rsp      out        rsp_valid/rsp_stall  rsp_data: running_task, ready_mask, ignored
//
//  A schedule tick first decrements one counter per cycle with the shared decrementer,
//  then tests one candidate per cycle in round-robin order until a ready task is found
//  or every candidate has failed, in which case the idle task runs. A self delay is
//  written in a state of its own before the walk; a delay write goes straight to finish.
//  Synchronous reset sets every counter to ready and makes the idle task current.
//  A new transaction is taken while the previous result waits under rsp_stall;
//  the block holds its last step until the result register is free.
module round_robin_delay_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rrds_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rrds_pkg::rsp_type rsp_data
);
   import rrds_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SELF,
      ST_WALK,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic                 ignored_ff, ignored_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   wr_cmd_type           wr;
   logic [DELAY_W-1:0]   rd_data;
   logic [NUM_TASKS-1:0] ready;
   logic [PAD_W-1:0]     ready_pad;
   logic                 accept;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   rrds_cnt_file u_cnt_file (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (idx_ff),
      .rd_data (rd_data),
      .ready   (ready)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign ready_pad = PAD_W'(ready);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      delay_in     = delay_ff;
      ignored_in   = ignored_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               delay_in   = req_data.delay;
               ignored_in = 1'b0;
               idx_in     = IDX_W'(1);
               case (req_data.mode)
                  MODE_SCHED: state_in = ST_WALK;
                  MODE_SELF:  state_in = ST_SELF;
                  MODE_SET: begin
                     if (req_data.task_req == '0) begin
                        ignored_in = 1'b1;
                     end else if (32'(req_data.task_req) < NUM_TASKS) begin
                        wr.en   = 1'b1;
                        wr.addr = IDX_W'(req_data.task_req);
                        wr.data = req_data.delay;
                     end
                     state_in = ST_FINISH;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_SELF: begin
            // The idle task cannot delay itself; the tick still runs.
            if (cur_ff != '0) begin
               wr.en   = 1'b1;
               wr.addr = cur_ff;
               wr.data = delay_ff;
            end
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (rd_data != '0 && rd_data != BLOCKED_FOREVER) begin
               wr.en   = 1'b1;
               wr.addr = idx_ff;
               wr.data = rd_data - 1'b1;
            end
            if (idx_ff == LAST_IDX) begin
               idx_in   = next_idx(cur_ff);
               cnt_in   = '0;
               state_in = ST_SEARCH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SEARCH: begin
            if (idx_ff != '0 && ready[idx_ff]) begin
               cur_in   = idx_ff;
               state_in = ST_FINISH;
            end else if (cnt_ff == CNT_W'(NUM_TASKS - 1)) begin
               cur_in   = '0;
               state_in = ST_FINISH;
            end else begin
               idx_in = next_idx(idx_ff);
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.running_task = 3'(cur_ff);
               rsp_data_in.ready_mask   = {ready_pad[7:1], 1'b0};
               rsp_data_in.ignored      = ignored_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      delay_ff    <= delay_in;
      ignored_ff  <= ignored_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/rrds_cnt_file.sv
module rrds_cnt_file (
   input  logic                         clock,
   input  logic                         reset,
   input  rrds_pkg::wr_cmd_type         wr,
   input  logic [rrds_pkg::IDX_W-1:0]   rd_addr,
   output logic [rrds_pkg::DELAY_W-1:0] rd_data,
   output logic [rrds_pkg::NUM_TASKS-1:0] ready
);
   import rrds_pkg::*;

   logic [DELAY_W-1:0]   cnt_ff [NUM_TASKS];
   logic [NUM_TASKS-1:0] ready_ff;

   // The ready bits mirror "counter is zero" so the search never needs the counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            cnt_ff[i] <= '0;
         end
         ready_ff <= '1;
      end else if (wr.en) begin
         cnt_ff[wr.addr]   <= wr.data;
         ready_ff[wr.addr] <= (wr.data == '0);
      end
   end

   assign rd_data = cnt_ff[rd_addr];
   assign ready   = ready_ff;

endmodule

### rtl/rrds_checker.sv
module rrds_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input rrds_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rrds_pkg::rsp_type rsp_data
);
   import rrds_pkg::*;

   // The idle task is never reported as ready.
   a_mask_bit0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.ready_mask[0])
      else $error("ready_mask bit 0 set");

   // An accepted transaction keeps the block busy on the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req_stall low right after an accepted transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

endmodule

bind round_robin_delay_scheduler rrds_checker u_rrds_checker (.*);

### dv/tb_round_robin_delay_scheduler.sv
`timescale 1ns / 100ps

module tb_round_robin_delay_scheduler;
   import rrds_pkg::*;

   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int IDLE_TASK = 0;
   localparam int RANDOM_ITEMS = 1100;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 60;
   localparam int MAX_PRINTED = 40;

   class task_sched_scoreboard;
      logic [DELAY_W-1:0] tick_delays [NUM_TASKS];
      int running_idx;
      rsp_type expected_rsp [$];
      int errors;

      function new();
         int i;
         for (i = 0; i < NUM_TASKS; i++) tick_delays[i] = '0;
         running_idx = IDLE_TASK;
         errors = 0;
      endfunction

      // Counters count down first, then the search starts one past the running
      // task and may wrap all the way back to it.
      function void sched_tick();
         int i;
         int idx;
         int pick;
         for (i = 1; i < NUM_TASKS; i++) begin
            if (tick_delays[i] != '0 && tick_delays[i] != BLOCKED_FOREVER)
               tick_delays[i] = tick_delays[i] - 1;
         end
         idx = running_idx;
         pick = IDLE_TASK;
         for (i = 0; i < NUM_TASKS; i++) begin
            idx = (idx + 1) % NUM_TASKS;
            if (idx != IDLE_TASK && tick_delays[idx] == '0) begin
               pick = idx;
               break;
            end
         end
         running_idx = pick;
      endfunction

      function logic [7:0] ready_bits();
         int i;
         logic [7:0] m;
         m = '0;
         for (i = 1; i < NUM_TASKS && i < 8; i++) begin
            if (tick_delays[i] == '0) m[i] = 1'b1;
         end
         return m;
      endfunction

      function void note_request(req_type r);
         rsp_type want;
         want.ignored = 1'b0;
         case (r.mode)
            MODE_SCHED: sched_tick();
            MODE_SET: begin
               if (int'(r.task_req) == IDLE_TASK) want.ignored = 1'b1;
               else if (int'(r.task_req) < NUM_TASKS) tick_delays[r.task_req] = r.delay;
            end
            MODE_SELF: begin
               if (running_idx != IDLE_TASK) tick_delays[running_idx] = r.delay;
               sched_tick();
            end
            default: ;
         endcase
         want.running_task = 3'(running_idx);
         want.ready_mask = ready_bits();
         expected_rsp.push_back(want);
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      task report_mismatch(string msg);
         if (errors < MAX_PRINTED) $display("%0t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("response %h with nothing expected", got));
            return;
         end
         want = expected_rsp.pop_front();
         if (got.running_task !== want.running_task)
            report_mismatch($sformatf("running_task %0d, expected %0d",
                                      got.running_task, want.running_task));
         if (got.ready_mask !== want.ready_mask)
            report_mismatch($sformatf("ready_mask %b, expected %b",
                                      got.ready_mask, want.ready_mask));
         if (got.ignored !== want.ignored)
            report_mismatch($sformatf("ignored %b, expected %b", got.ignored, want.ignored));
      endtask

      task report_leftover();
         if (expected_rsp.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_rsp.size()));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   task_sched_scoreboard sb = new();
   bit quiet = 1'b0;
   int stuck_cycles = 0;

   round_robin_delay_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         rsp_stall <= !quiet && ($urandom_range(99) < 11);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   function automatic req_type make_req(logic [1:0] mode, int task_idx, logic [31:0] dly);
      req_type r;
      r.mode = mode;
      r.task_req = 3'(task_idx);
      r.delay = dly;
      return r;
   endfunction

   // Mostly short delays so tasks keep cycling; a few forever-blocked and
   // huge values, plus the unused mode, act as noise.
   function automatic req_type random_req();
      req_type r;
      int sel;
      sel = $urandom_range(99);
      if (sel < 45) r.mode = MODE_SCHED;
      else if (sel < 72) r.mode = MODE_SET;
      else if (sel < 94) r.mode = MODE_SELF;
      else r.mode = MODE_SPARE;
      r.task_req = ($urandom_range(9) == 0) ? 3'(IDLE_TASK) : 3'($urandom_range(7));
      sel = $urandom_range(99);
      if (sel < 30) r.delay = '0;
      else if (sel < 75) r.delay = $urandom_range(12, 1);
      else if (sel < 84) r.delay = BLOCKED_FOREVER;
      else if (sel < 88) r.delay = BLOCKED_FOREVER - 1;
      else r.delay = $urandom();
      return r;
   endfunction

   task automatic send_request(req_type r);
      if (!quiet) begin
         while ($urandom_range(99) < 11) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, starting from every task ready and idle running.
      send_request(make_req(MODE_SET, IDLE_TASK, 32'd5));
      send_request(make_req(MODE_SPARE, 7, 32'hFFFF_FFFF));
      send_request(make_req(MODE_SCHED, 0, 32'd0));
      send_request(make_req(MODE_SELF, 0, BLOCKED_FOREVER));
      send_request(make_req(MODE_SET, 3, BLOCKED_FOREVER - 1));
      send_request(make_req(MODE_SET, 4, 32'h8000_0000));
      send_request(make_req(MODE_SET, 5, 32'd1));
      send_request(make_req(MODE_SET, 6, BLOCKED_FOREVER));
      send_request(make_req(MODE_SET, 7, BLOCKED_FOREVER));
      send_request(make_req(MODE_SCHED, 0, 32'd0));
      send_request(make_req(MODE_SET, 2, BLOCKED_FOREVER));
      // Only the running task stays ready, so the search wraps back to it,
      // and a self delay of one is used up on the same tick.
      send_request(make_req(MODE_SELF, 0, 32'd1));
      send_request(make_req(MODE_SELF, 0, 32'd0));
      send_request(make_req(MODE_SET, 5, BLOCKED_FOREVER));
      send_request(make_req(MODE_SCHED, 0, 32'd0));
      // Nothing is ready now, so the idle task runs and its own delay is dropped.
      send_request(make_req(MODE_SELF, 0, 32'd7));
      send_request(make_req(MODE_SET, IDLE_TASK, 32'd0));
      send_request(make_req(MODE_SET, 2, 32'd0));
      send_request(make_req(MODE_SET, 1, 32'd0));
      send_request(make_req(MODE_SET, 7, 32'd2));
      send_request(make_req(MODE_SCHED, 0, 32'd0));
      send_request(make_req(MODE_SCHED, 0, 32'd0));
      for (n = 3; n < 8; n++) send_request(make_req(MODE_SET, n, 32'd0));
      drain_responses();

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= 400 && n < 700);
         send_request(random_req());
         if (n % 250 == 249) drain_responses();
      end
      quiet = 1'b0;

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.report_leftover();
      if (sb.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
